// File: rtl/core/fcc_pkg.sv
// shared constants and types of the frame cross-correlator
package fcc_pkg;

  localparam int DEF_MAX_FRAME   = 64;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int MIN_FRAME       = 2;
  localparam int FIELD_BITS      = 16;
  localparam int LEN_BITS        = 7;
  localparam int LAG_BITS        = 6;
  localparam int OUT_BITS        = 39;
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(64);

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: rtl/core/fcc_store.sv
// sample memory holding one frame of reference and surveillance pairs
module fcc_store #(
  parameter int SAMPLE_BITS = fcc_pkg::DEF_SAMPLE_BITS,
  parameter int DEPTH       = fcc_pkg::DEF_MAX_FRAME
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_ref_re,
  input  logic signed [SAMPLE_BITS-1:0] wr_ref_im,
  input  logic signed [SAMPLE_BITS-1:0] wr_surv_re,
  input  logic signed [SAMPLE_BITS-1:0] wr_surv_im,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic signed [SAMPLE_BITS-1:0] rd_ref_re,
  output logic signed [SAMPLE_BITS-1:0] rd_ref_im,
  output logic signed [SAMPLE_BITS-1:0] rd_surv_re,
  output logic signed [SAMPLE_BITS-1:0] rd_surv_im
);
  import fcc_pkg::*;

  localparam int WORD_BITS = 4 * SAMPLE_BITS;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_ref_re, wr_ref_im, wr_surv_re, wr_surv_im};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_ref_re  = rd_word[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
  assign rd_ref_im  = rd_word[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign rd_surv_re = rd_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign rd_surv_im = rd_word[SAMPLE_BITS-1:0];

endmodule

// File: rtl/core/fcc_cell.sv
// one lag cell: delayed reference tap, conjugate product and lag accumulator
module fcc_cell #(
  parameter int SAMPLE_BITS = fcc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fcc_pkg::cell_ctrl_t                ctrl,
  input  logic                               step,
  input  logic                               ref_in_valid,
  input  logic signed [SAMPLE_BITS-1:0]      ref_in_re,
  input  logic signed [SAMPLE_BITS-1:0]      ref_in_im,
  input  logic signed [SAMPLE_BITS-1:0]      surv_re,
  input  logic signed [SAMPLE_BITS-1:0]      surv_im,
  output logic                               ref_out_valid,
  output logic signed [SAMPLE_BITS-1:0]      ref_out_re,
  output logic signed [SAMPLE_BITS-1:0]      ref_out_im,
  input  logic signed [fcc_pkg::OUT_BITS-1:0] acc_in_re,
  input  logic signed [fcc_pkg::OUT_BITS-1:0] acc_in_im,
  output logic signed [fcc_pkg::OUT_BITS-1:0] acc_re,
  output logic signed [fcc_pkg::OUT_BITS-1:0] acc_im
);
  import fcc_pkg::*;

  localparam int PROD_BITS = 2 * SAMPLE_BITS + 1;

  logic                        prod_valid;
  logic signed [PROD_BITS-1:0] prod_re;
  logic signed [PROD_BITS-1:0] prod_im;
  logic signed [PROD_BITS-1:0] prod_re_next;
  logic signed [PROD_BITS-1:0] prod_im_next;

  // surv times conj(ref)
  always_comb begin
    prod_re_next = PROD_BITS'(surv_re) * PROD_BITS'(ref_in_re)
                 + PROD_BITS'(surv_im) * PROD_BITS'(ref_in_im);
    prod_im_next = PROD_BITS'(surv_im) * PROD_BITS'(ref_in_re)
                 - PROD_BITS'(surv_re) * PROD_BITS'(ref_in_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_out_valid <= 1'b0;
      prod_valid    <= 1'b0;
    end else begin
      ref_out_valid <= ref_in_valid;
      prod_valid    <= ref_in_valid && step;
    end
  end

  always_ff @(posedge clk) begin
    ref_out_re <= ref_in_re;
    ref_out_im <= ref_in_im;
    prod_re    <= prod_re_next;
    prod_im    <= prod_im_next;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (ctrl.shift) begin
      acc_re <= acc_in_re;
      acc_im <= acc_in_im;
    end else if (prod_valid) begin
      acc_re <= acc_re + OUT_BITS'(prod_re);
      acc_im <= acc_im + OUT_BITS'(prod_im);
    end
  end

endmodule

// File: rtl/core/frame_cross_correlator_unit.sv
// Frame cross-correlator: one pair transaction per cycle is taken until a frame of L pairs
// (L = frame_length held to 2 .. MAX_FRAME) is stored; the frame is then read back from the
// sample memory one pair per cycle through a chain of MAX_FRAME lag cells, and the L lag
// results leave at one per cycle, lag 0 first, as the output side takes them. No pair is
// taken from the last pair of a frame until its last result is taken.
module frame_cross_correlator_unit #(
  parameter int MAX_FRAME   = fcc_pkg::DEF_MAX_FRAME,
  parameter int SAMPLE_BITS = fcc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [fcc_pkg::LEN_BITS-1:0]         cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [fcc_pkg::FIELD_BITS-1:0] ref_real,
  input  logic signed [fcc_pkg::FIELD_BITS-1:0] ref_imag,
  input  logic signed [fcc_pkg::FIELD_BITS-1:0] surv_real,
  input  logic signed [fcc_pkg::FIELD_BITS-1:0] surv_imag,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [fcc_pkg::LAG_BITS-1:0]         lag_index,
  output logic signed [fcc_pkg::OUT_BITS-1:0]  corr_real,
  output logic signed [fcc_pkg::OUT_BITS-1:0]  corr_imag,
  output logic                                 frame_end
);
  import fcc_pkg::*;

  localparam int AW = $clog2(MAX_FRAME);
  localparam int LW = $clog2(MAX_FRAME + 1);
  localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_FRAME);
  localparam logic [LEN_BITS-1:0] MIN_LEN = LEN_BITS'(MIN_FRAME);

  typedef enum logic [1:0] {COLLECT, COMPUTE, DRAIN, EMIT} state_t;

  state_t            state;
  logic [LEN_BITS-1:0] frame_len;
  logic [AW-1:0]     count;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     out_cnt;
  logic              mem_valid;
  logic              prod_pending;
  logic [LW-1:0]     eff_len;
  logic [LW-1:0]     last_pos;
  logic              in_take;
  logic              out_take;
  logic              frame_done;
  logic              rd_en;
  cell_ctrl_t        ctrl;

  logic signed [SAMPLE_BITS-1:0] in_rr, in_ri, in_sr, in_si;
  logic signed [SAMPLE_BITS-1:0] mem_rr, mem_ri, mem_sr, mem_si;

  logic                          chain_valid [MAX_FRAME];
  logic signed [SAMPLE_BITS-1:0] chain_re    [MAX_FRAME];
  logic signed [SAMPLE_BITS-1:0] chain_im    [MAX_FRAME];
  logic signed [OUT_BITS-1:0]    acc_re      [MAX_FRAME];
  logic signed [OUT_BITS-1:0]    acc_im      [MAX_FRAME];

  always_comb begin
    priority if (frame_len < MIN_LEN) begin
      eff_len = LW'(MIN_LEN);
    end else if (frame_len > MAX_LEN) begin
      eff_len = LW'(MAX_LEN);
    end else begin
      eff_len = LW'(frame_len);
    end
  end

  assign last_pos   = eff_len - LW'(1);
  assign in_rr      = SAMPLE_BITS'(unsigned'(ref_real));
  assign in_ri      = SAMPLE_BITS'(unsigned'(ref_imag));
  assign in_sr      = SAMPLE_BITS'(unsigned'(surv_real));
  assign in_si      = SAMPLE_BITS'(unsigned'(surv_imag));

  assign sample_stall = (state != COLLECT);
  assign result_valid = (state == EMIT);
  assign in_take      = sample_valid && !sample_stall;
  assign out_take     = result_valid && !result_stall;
  assign frame_done   = (LW'(count) + LW'(1)) >= eff_len;
  assign rd_en        = (state == COMPUTE);
  assign ctrl.clear   = in_take && frame_done;
  assign ctrl.shift   = out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len <= LEN_RESET;
    end else if (cfg_write) begin
      frame_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= COLLECT;
      count        <= '0;
      rd_addr      <= '0;
      out_cnt      <= '0;
      mem_valid    <= 1'b0;
      prod_pending <= 1'b0;
    end else begin
      mem_valid    <= rd_en;
      prod_pending <= mem_valid;
      unique case (state)
        COLLECT: begin
          if (in_take) begin
            if (frame_done) begin
              count   <= '0;
              rd_addr <= '0;
              state   <= COMPUTE;
            end else begin
              count <= count + AW'(1);
            end
          end
        end
        COMPUTE: begin
          rd_addr <= rd_addr + AW'(1);
          if (LW'(rd_addr) == last_pos) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!mem_valid && !prod_pending) begin
            out_cnt <= '0;
            state   <= EMIT;
          end
        end
        EMIT: begin
          if (out_take) begin
            out_cnt <= out_cnt + AW'(1);
            if (LW'(out_cnt) == last_pos) begin
              state <= COLLECT;
            end
          end
        end
        default: state <= COLLECT;
      endcase
    end
  end

  fcc_store #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .DEPTH      (MAX_FRAME)
  ) u_store (
    .clk       (clk),
    .wr_en     (in_take),
    .wr_addr   (count),
    .wr_ref_re (in_rr),
    .wr_ref_im (in_ri),
    .wr_surv_re(in_sr),
    .wr_surv_im(in_si),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_ref_re (mem_rr),
    .rd_ref_im (mem_ri),
    .rd_surv_re(mem_sr),
    .rd_surv_im(mem_si)
  );

  // cell k pairs surveillance sample n with reference sample n - k (lag k)
  for (genvar k = 0; k < MAX_FRAME; k++) begin : g_cell
    logic                          tap_valid;
    logic signed [SAMPLE_BITS-1:0] tap_re;
    logic signed [SAMPLE_BITS-1:0] tap_im;
    logic signed [OUT_BITS-1:0]    next_re;
    logic signed [OUT_BITS-1:0]    next_im;

    if (k == 0) begin : g_head
      assign tap_valid = mem_valid;
      assign tap_re    = mem_rr;
      assign tap_im    = mem_ri;
    end else begin : g_body
      assign tap_valid = chain_valid[k-1];
      assign tap_re    = chain_re[k-1];
      assign tap_im    = chain_im[k-1];
    end

    if (k == MAX_FRAME - 1) begin : g_tail
      assign next_re = '0;
      assign next_im = '0;
    end else begin : g_link
      assign next_re = acc_re[k+1];
      assign next_im = acc_im[k+1];
    end

    fcc_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .step         (mem_valid),
      .ref_in_valid (tap_valid),
      .ref_in_re    (tap_re),
      .ref_in_im    (tap_im),
      .surv_re      (mem_sr),
      .surv_im      (mem_si),
      .ref_out_valid(chain_valid[k]),
      .ref_out_re   (chain_re[k]),
      .ref_out_im   (chain_im[k]),
      .acc_in_re    (next_re),
      .acc_in_im    (next_im),
      .acc_re       (acc_re[k]),
      .acc_im       (acc_im[k])
    );
  end

  assign lag_index = LAG_BITS'(out_cnt);
  assign corr_real = acc_re[0];
  assign corr_imag = acc_im[0];
  assign frame_end = (LW'(out_cnt) == last_pos);

endmodule

// File: dv/tb_frame_cross_correlator_unit.sv
// testbench of the frame cross-correlator: table and random transactions against a predictor
module tb_frame_cross_correlator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fcc_pkg::*;

  localparam int MAX_FRAME      = DEF_MAX_FRAME;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 2 * MAX_FRAME + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_DIRECTED     = 25;
  localparam int N_PHASES       = 11;
  localparam logic signed [FIELD_BITS-1:0] S_MIN = 16'sh8000;
  localparam logic signed [FIELD_BITS-1:0] S_MAX = 16'sh7FFF;

  typedef enum bit {ROW_CONFIG, ROW_PAIR} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [LEN_BITS-1:0]           length;
    logic signed [FIELD_BITS-1:0]  rr;
    logic signed [FIELD_BITS-1:0]  ri;
    logic signed [FIELD_BITS-1:0]  sr;
    logic signed [FIELD_BITS-1:0]  si;
    bit                            typed;
    logic signed [OUT_BITS-1:0]    lag0_re;
    logic signed [OUT_BITS-1:0]    lag0_im;
  } pair_row_t;

  typedef struct packed {
    logic [LAG_BITS-1:0]         lag;
    logic signed [OUT_BITS-1:0]  re;
    logic signed [OUT_BITS-1:0]  im;
    logic                        last;
  } lag_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [LEN_BITS-1:0]           cfg_data = '0;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  logic signed [FIELD_BITS-1:0]  ref_real = '0;
  logic signed [FIELD_BITS-1:0]  ref_imag = '0;
  logic signed [FIELD_BITS-1:0]  surv_real = '0;
  logic signed [FIELD_BITS-1:0]  surv_imag = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [LAG_BITS-1:0]           lag_index;
  logic signed [OUT_BITS-1:0]    corr_real;
  logic signed [OUT_BITS-1:0]    corr_imag;
  logic                          frame_end;

  // predictor state
  logic [LEN_BITS-1:0]           frame_len = LEN_RESET;
  int                            fill_count = 0;
  logic signed [FIELD_BITS-1:0]  ref_re_mem [MAX_FRAME];
  logic signed [FIELD_BITS-1:0]  ref_im_mem [MAX_FRAME];
  logic signed [FIELD_BITS-1:0]  surv_re_mem [MAX_FRAME];
  logic signed [FIELD_BITS-1:0]  surv_im_mem [MAX_FRAME];

  lag_result_t                   pending_lags [$];
  int                            mismatch_count = 0;
  int                            quiet_cycles = 0;
  int                            sender_gap_pct = 32;
  int                            receiver_stall_pct = 72;

  pair_row_t                     directed_rows [N_DIRECTED];
  logic [LEN_BITS-1:0]           phase_len [N_PHASES] = '{
    7'd127, 7'd4, 7'd9, 7'd0, 7'd13, 7'd2, 7'd65, 7'd7, 7'd31, 7'd3, 7'd16
  };

  frame_cross_correlator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .ref_real     (ref_real),
    .ref_imag     (ref_imag),
    .surv_real    (surv_real),
    .surv_imag    (surv_imag),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .lag_index    (lag_index),
    .corr_real    (corr_real),
    .corr_imag    (corr_imag),
    .frame_end    (frame_end)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int effective_span(input logic [LEN_BITS-1:0] v);
    if (v < MIN_FRAME) return MIN_FRAME;
    if (v > MAX_FRAME) return MAX_FRAME;
    return int'(v);
  endfunction

  // stores one pair and, on a full frame, queues every lag sum
  function automatic int correlate_pair(input pair_row_t row);
    int span;
    int slot;
    int k;
    int n;
    longint acc_re;
    longint acc_im;
    lag_result_t res;
    span = effective_span(frame_len);
    slot = (fill_count >= MAX_FRAME) ? MAX_FRAME - 1 : fill_count;
    ref_re_mem[slot]  = row.rr;
    ref_im_mem[slot]  = row.ri;
    surv_re_mem[slot] = row.sr;
    surv_im_mem[slot] = row.si;
    fill_count = (slot + 1) % 128;
    if (fill_count < span) return 0;
    for (k = 0; k < span; k++) begin
      acc_re = 0;
      acc_im = 0;
      for (n = 0; n + k < span; n++) begin
        acc_re += longint'(surv_re_mem[n+k]) * longint'(ref_re_mem[n])
                + longint'(surv_im_mem[n+k]) * longint'(ref_im_mem[n]);
        acc_im += longint'(surv_im_mem[n+k]) * longint'(ref_re_mem[n])
                - longint'(surv_re_mem[n+k]) * longint'(ref_im_mem[n]);
      end
      res.lag  = LAG_BITS'(k);
      res.re   = acc_re[OUT_BITS-1:0];
      res.im   = acc_im[OUT_BITS-1:0];
      res.last = (k + 1 == span);
      pending_lags.push_back(res);
    end
    fill_count = 0;
    return span;
  endfunction

  function automatic logic signed [FIELD_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending_lags.size() != 0);
  endtask

  task automatic write_frame_length(input logic [LEN_BITS-1:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    frame_len = v;
  endtask

  task automatic send_pair(input pair_row_t row);
    int produced;
    while ($urandom_range(99) < sender_gap_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    ref_real     <= row.rr;
    ref_imag     <= row.ri;
    surv_real    <= row.sr;
    surv_imag    <= row.si;
    do @(posedge clk); while (sample_stall);
    produced = correlate_pair(row);
    if (row.typed && produced > 0) begin
      pending_lags[pending_lags.size() - produced].re = row.lag0_re;
      pending_lags[pending_lags.size() - produced].im = row.lag0_im;
    end
  endtask

  // result checking and watchdog
  always @(posedge clk) begin : result_monitor
    lag_result_t seen;
    lag_result_t wanted;
    if (!rst) begin
      seen = '{lag: lag_index, re: corr_real, im: corr_imag, last: frame_end};
      if (result_valid && !result_stall) begin
        if (pending_lags.size() == 0) begin
          $display("%0t unexpected transaction: lag %0d re %0d im %0d end %0b",
                   $time, seen.lag, seen.re, seen.im, seen.last);
          mismatch_count++;
        end else begin
          wanted = pending_lags.pop_front();
          if (seen !== wanted) begin
            $display("%0t mismatch: expected lag %0d re %0d im %0d end %0b", $time,
                     wanted.lag, wanted.re, wanted.im, wanted.last);
            $display("%0t           actual   lag %0d re %0d im %0d end %0b", $time,
                     seen.lag, seen.re, seen.im, seen.last);
            mismatch_count++;
          end
        end
      end
      if ((result_valid && !result_stall) || (sample_valid && !sample_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      result_stall <= ($urandom_range(99) < receiver_stall_pct);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    pair_row_t row;
    int span;
    int frames;
    directed_rows = '{
      '{ROW_CONFIG, 7'd0,   16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   S_MIN, S_MIN, S_MIN, S_MIN, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   S_MIN, S_MIN, S_MIN, S_MIN, 1'b1, 39'sd4294967296, 39'sd0},
      '{ROW_CONFIG, 7'd1,   16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   S_MAX, 16'sh0, S_MAX, 16'sh0, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   S_MAX, 16'sh0, S_MAX, 16'sh0, 1'b1, 39'sd2147352578, 39'sd0},
      '{ROW_PAIR,   7'd0,   S_MAX, S_MIN, S_MIN, S_MAX, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   S_MAX, S_MIN, S_MIN, S_MAX, 1'b1,
        -39'sd4294836224, -39'sd131070},
      '{ROW_CONFIG, 7'd3,   16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh1234, 16'shFA99, 16'sh0F0F, 16'shC001, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh8001, 16'sh7FFE, 16'shFFFF, 16'sh0001, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh5555, 16'shAAAA, 16'sh3C3C, 16'shC3C3, 1'b0, 39'sd0, 39'sd0},
      '{ROW_CONFIG, 7'd6,   16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'shF000, 16'sh0FFF, 16'sh7000, 16'sh9000, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh0001, 16'shFFFF, 16'sh8000, 16'sh7FFF, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh2468, 16'sh1357, 16'shECA8, 16'sh9BDF, 1'b0, 39'sd0, 39'sd0},
      // shrink below the stored count: the next pair closes the frame
      '{ROW_CONFIG, 7'd3,   16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh4000, 16'shC000, 16'sh2000, 16'shE000, 1'b0, 39'sd0, 39'sd0},
      '{ROW_CONFIG, 7'd5,   16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh7123, 16'sh8456, 16'sh0789, 16'shFABC, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh1111, 16'sh2222, 16'sh3333, 16'sh4444, 1'b0, 39'sd0, 39'sd0},
      // shrink while still above the stored count
      '{ROW_CONFIG, 7'd4,   16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'shDEAD, 16'shBEEF, 16'sh0BAD, 16'shF00D, 1'b0, 39'sd0, 39'sd0},
      '{ROW_PAIR,   7'd0,   16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh8000, 1'b0, 39'sd0, 39'sd0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG)
        write_frame_length(directed_rows[i].length);
      else
        send_pair(directed_rows[i]);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 4) begin
        sender_gap_pct     = 72;
        receiver_stall_pct = 32;
      end else if (p == 8) begin
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
      end
      write_frame_length(phase_len[p]);
      span   = effective_span(phase_len[p]);
      frames = (span >= 20) ? 1 : 20 / span;
      for (int f = 0; f < frames; f++) begin
        for (int s = 0; s < span; s++) begin
          row = '0;
          row.kind = ROW_PAIR;
          row.rr = pick_sample();
          row.ri = pick_sample();
          row.sr = pick_sample();
          row.si = pick_sample();
          send_pair(row);
        end
        if ($urandom_range(5) == 0) drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
